[rtl/wsfp_pkg.sv]
`timescale 1ns / 1ps
package wsfp_pkg;

  localparam int PhaseW = 3;
  localparam int LenW   = 64;
  localparam int KeyW   = 32;

  typedef logic [PhaseW-1:0] phase_t;

  localparam phase_t PH_HDR0  = 3'd0;
  localparam phase_t PH_HDR1  = 3'd1;
  localparam phase_t PH_LEN16 = 3'd2;
  localparam phase_t PH_LEN64 = 3'd3;
  localparam phase_t PH_KEY   = 3'd4;
  localparam phase_t PH_DATA  = 3'd5;

  localparam logic       KIND_HEADER = 1'b0;
  localparam logic       KIND_DATA   = 1'b1;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    logic            item_kind;
    logic [7:0]      hdr;
    logic            masked;
    logic [LenW-1:0] length;
    logic [7:0]      data_byte;
    logic            last;
  } res_t;

endpackage

[rtl/websocket_frame_header_parser_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_byte, in_restart
// out_      output     out_valid / out_stall  header fields, out_data_byte, out_last
// cfg_      input      cfg_wr_en              cfg_wr_data (unmask enable)
//
// One byte is accepted per clock while in_stall is low; its result, if any, is
// registered the next cycle. The parser state update is a single 64-bit shift,
// decrement and compare per byte. A result register plus one skid entry decouple
// the two sides; in_stall is only raised while the skid entry is occupied.
// rst_n is synchronous and returns the parser to the first header byte.
module websocket_frame_header_parser_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_byte,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_item_kind,
  output logic                    out_fin_bit,
  output logic                    out_rsv1_bit,
  output logic                    out_rsv2_bit,
  output logic                    out_rsv3_bit,
  output logic [3:0]              out_opcode,
  output logic                    out_masked,
  output logic [wsfp_pkg::LenW-1:0] out_frame_payload_length,
  output logic [7:0]              out_data_byte,
  output logic                    out_last,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data
);
  import wsfp_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      hdr_r, hdr_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [LenW-1:0] left_r, left_nxt;
  logic [1:0]      kpos_r, kpos_nxt;
  logic            mflag_r, mflag_nxt;
  logic            unmask_r;

  logic            acc;
  logic            gen;
  logic            out_take;
  logic            out_valid_r, skid_valid_r;
  res_t            out_r, skid_r, res;
  logic            hdr_done;
  logic [2:0]      cnt_inc;
  logic [7:0]      key_byte;
  logic            data_last;

  assign acc      = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    left_nxt  = left_r;
    kpos_nxt  = kpos_r;
    mflag_nxt = mflag_r;
    hdr_done  = 1'b0;
    gen       = 1'b0;
    cnt_inc   = cnt_r + 3'd1;
    // Key byte 0 sits in bits 31..24, so the offset is 8 * (3 - position).
    key_byte  = key_r[{~kpos_r, 3'b000} +: 8];
    data_last = (left_r <= LenW'(1));
    res.item_kind = KIND_DATA;
    res.data_byte = in_byte;
    res.last      = data_last;

    if (in_restart) begin
      phase_nxt = PH_HDR0;
      hdr_nxt   = '0;
      cnt_nxt   = '0;
      len_nxt   = '0;
      key_nxt   = '0;
      left_nxt  = '0;
      kpos_nxt  = '0;
      mflag_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_HDR0: begin
          hdr_nxt   = in_byte;
          mflag_nxt = 1'b0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mflag_nxt = in_byte[7];
          cnt_nxt   = '0;
          len_nxt   = '0;
          if (in_byte[6:0] == LEN7_EXT16) begin
            phase_nxt = PH_LEN16;
          end else if (in_byte[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_LEN64;
          end else begin
            len_nxt = LenW'(in_byte[6:0]);
            if (in_byte[7]) begin
              key_nxt   = '0;
              phase_nxt = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          len_nxt = {len_r[LenW-9:0], in_byte};
          cnt_nxt = cnt_inc;
          if ((phase_r == PH_LEN16 && cnt_inc == 3'd2) ||
              (phase_r == PH_LEN64 && cnt_inc == 3'd0)) begin
            cnt_nxt = '0;
            if (mflag_r) begin
              key_nxt   = '0;
              phase_nxt = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[KeyW-9:0], in_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc == 3'd4) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          gen = 1'b1;
          if (mflag_r && unmask_r) begin
            res.data_byte = in_byte ^ key_byte;
          end
          kpos_nxt = kpos_r + 2'd1;
          if (left_r != '0) begin
            left_nxt = left_r - LenW'(1);
          end
          if (data_last) begin
            phase_nxt = PH_HDR0;
            left_nxt  = '0;
            kpos_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
          hdr_nxt   = '0;
          cnt_nxt   = '0;
          len_nxt   = '0;
          key_nxt   = '0;
          left_nxt  = '0;
          kpos_nxt  = '0;
          mflag_nxt = 1'b0;
        end
      endcase

      // Header complete: report it and arm the payload countdown.
      if (hdr_done) begin
        gen           = 1'b1;
        res.item_kind = KIND_HEADER;
        res.data_byte = '0;
        res.last      = (len_nxt == '0);
        cnt_nxt       = '0;
        kpos_nxt      = '0;
        left_nxt      = len_nxt;
        phase_nxt     = (len_nxt == '0) ? PH_HDR0 : PH_DATA;
      end
    end

    res.hdr    = hdr_nxt;
    res.masked = mflag_nxt;
    res.length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      hdr_r        <= '0;
      cnt_r        <= '0;
      len_r        <= '0;
      key_r        <= '0;
      left_r       <= '0;
      kpos_r       <= '0;
      mflag_r      <= 1'b0;
      unmask_r     <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unmask_r <= cfg_wr_data;
      end
      if (acc) begin
        phase_r <= phase_nxt;
        hdr_r   <= hdr_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
        key_r   <= key_nxt;
        left_r  <= left_nxt;
        kpos_r  <= kpos_nxt;
        mflag_r <= mflag_nxt;
      end
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= acc && gen;
        end
      end else if (acc && gen) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (acc && gen) begin
        out_r <= res;
      end
    end else if (acc && gen) begin
      skid_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_item_kind            = out_r.item_kind;
  assign out_fin_bit              = out_r.hdr[7];
  assign out_rsv1_bit             = out_r.hdr[6];
  assign out_rsv2_bit             = out_r.hdr[5];
  assign out_rsv3_bit             = out_r.hdr[4];
  assign out_opcode               = out_r.hdr[3:0];
  assign out_masked               = out_r.masked;
  assign out_frame_payload_length = out_r.length;
  assign out_data_byte            = out_r.data_byte;
  assign out_last                 = out_r.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied while result register is empty");

  a_last_byte_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_restart && phase_r == PH_DATA && left_r <= LenW'(1))
      |=> phase_r == PH_HDR0)
    else $error("parser did not return to header after last payload byte");

  a_kpos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DATA) |-> (kpos_r == 2'd0))
    else $error("key position nonzero outside payload");

  a_empty_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_kind == KIND_HEADER && out_last)
      |-> (out_frame_payload_length == '0))
    else $error("header marked last with nonzero length");

  a_phase_legal_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY) |-> (cnt_r < 3'd4))
    else $error("key byte count out of range");

endmodule

[tb/tb_websocket_frame_header_parser_core.sv]
`timescale 1ns / 1ps
module tb_websocket_frame_header_parser_core;
  import wsfp_pkg::*;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One request on the byte channel, with an optional hand-typed expectation.
  typedef struct packed {
    logic       rst;
    logic [7:0] data;
    logic       chk;
    res_t       want;
  } req_t;

  typedef struct {
    row_kind_t kind;
    req_t      req;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_item_kind;
  logic out_fin_bit;
  logic out_rsv1_bit;
  logic out_rsv2_bit;
  logic out_rsv3_bit;
  logic [3:0] out_opcode;
  logic out_masked;
  logic [LenW-1:0] out_frame_payload_length;
  logic [7:0] out_data_byte;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  // Parser state as the block should hold it.
  phase_t      ps_phase;
  logic [7:0]  hdr_byte;
  logic [2:0]  fld_count;
  logic [63:0] frame_len;
  logic [31:0] key_word;
  logic [63:0] remaining;
  logic [1:0]  key_idx;
  logic        mask_bit;
  logic        unmask_on;

  res_t parsed_q[$];
  req_t req_q[$];
  row_t dir_tab[$];
  bit   in_taken = 1'b0;
  int   errors = 0;
  int   req_count = 0;
  int   cyc = 0;
  int   stuck_cycles = 0;

  websocket_frame_header_parser_core DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_byte                  (in_byte),
    .in_restart               (in_restart),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_item_kind            (out_item_kind),
    .out_fin_bit              (out_fin_bit),
    .out_rsv1_bit             (out_rsv1_bit),
    .out_rsv2_bit             (out_rsv2_bit),
    .out_rsv3_bit             (out_rsv3_bit),
    .out_opcode               (out_opcode),
    .out_masked               (out_masked),
    .out_frame_payload_length (out_frame_payload_length),
    .out_data_byte            (out_data_byte),
    .out_last                 (out_last),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic void clear_frame();
    ps_phase = PH_HDR0;
    hdr_byte = 8'h00;
    fld_count = 3'd0;
    frame_len = 64'd0;
    key_word = 32'd0;
    remaining = 64'd0;
    key_idx = 2'd0;
    mask_bit = 1'b0;
  endfunction

  function automatic res_t make_res(logic kind, logic [7:0] d, logic fin_item);
    res_t r;
    r.item_kind = kind;
    r.hdr = hdr_byte;
    r.masked = mask_bit;
    r.length = frame_len;
    r.data_byte = d;
    r.last = fin_item;
    return r;
  endfunction

  function automatic bit header_done(output res_t r);
    r = make_res(KIND_HEADER, 8'h00, frame_len == 64'd0);
    fld_count = 3'd0;
    key_idx = 2'd0;
    remaining = frame_len;
    ps_phase = (frame_len == 64'd0) ? PH_HDR0 : PH_DATA;
    return 1'b1;
  endfunction

  // With the length known, a masked frame still has its key to read.
  function automatic bit length_done(output res_t r);
    r = '0;
    fld_count = 3'd0;
    if (mask_bit) begin
      key_word = 32'd0;
      ps_phase = PH_KEY;
      return 1'b0;
    end
    return header_done(r);
  endfunction

  function automatic bit parse_byte(logic rst, logic [7:0] b, output res_t r);
    bit emit;
    logic [7:0] d;
    emit = 1'b0;
    r = '0;
    if (rst) begin
      clear_frame();
      return 1'b0;
    end
    case (ps_phase)
      PH_HDR0: begin
        hdr_byte = b;
        mask_bit = 1'b0;
        frame_len = 64'd0;
        fld_count = 3'd0;
        ps_phase = PH_HDR1;
      end
      PH_HDR1: begin
        mask_bit = b[7];
        fld_count = 3'd0;
        frame_len = 64'd0;
        if (b[6:0] == LEN7_EXT16) ps_phase = PH_LEN16;
        else if (b[6:0] == LEN7_EXT64) ps_phase = PH_LEN64;
        else begin
          frame_len = {57'd0, b[6:0]};
          emit = length_done(r);
        end
      end
      PH_LEN16, PH_LEN64: begin
        frame_len = {frame_len[55:0], b};
        fld_count = fld_count + 3'd1;
        if ((ps_phase == PH_LEN16 && fld_count == 3'd2) ||
            (ps_phase == PH_LEN64 && fld_count == 3'd0)) emit = length_done(r);
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        fld_count = fld_count + 3'd1;
        if (fld_count == 3'd4) emit = header_done(r);
      end
      PH_DATA: begin
        d = b;
        if (mask_bit && unmask_on) d = d ^ key_word[{~key_idx, 3'b111} -: 8];
        key_idx = key_idx + 2'd1;
        r = make_res(KIND_DATA, d, remaining <= 64'd1);
        emit = 1'b1;
        if (remaining > 64'd0) remaining = remaining - 64'd1;
        if (r.last) begin
          ps_phase = PH_HDR0;
          remaining = 64'd0;
          key_idx = 2'd0;
        end
      end
      default: clear_frame();
    endcase
    return emit;
  endfunction

  function automatic void cmp_field(string what, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic check_result();
    res_t w;
    if (parsed_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got kind %0d data %h", $time,
               out_item_kind, out_data_byte);
      errors++;
    end else begin
      w = parsed_q.pop_front();
      cmp_field("item_kind", 64'(w.item_kind), 64'(out_item_kind));
      cmp_field("fin_bit", 64'(w.hdr[7]), 64'(out_fin_bit));
      cmp_field("rsv1_bit", 64'(w.hdr[6]), 64'(out_rsv1_bit));
      cmp_field("rsv2_bit", 64'(w.hdr[5]), 64'(out_rsv2_bit));
      cmp_field("rsv3_bit", 64'(w.hdr[4]), 64'(out_rsv3_bit));
      cmp_field("opcode", 64'(w.hdr[3:0]), 64'(out_opcode));
      cmp_field("masked", 64'(w.masked), 64'(out_masked));
      cmp_field("frame_payload_length", w.length, out_frame_payload_length);
      cmp_field("data_byte", 64'(w.data_byte), 64'(out_data_byte));
      cmp_field("last", 64'(w.last), 64'(out_last));
    end
  endtask

  // Both sides periodically run without gaps for a long stretch.
  function automatic bit idle_now();
    return ((cyc % 3000) >= 600) && ($urandom_range(0, 99) < 20);
  endfunction

  always @(posedge clk) begin : monitor
    res_t r;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        if (req_q[0].chk) begin
          void'(parse_byte(in_restart, in_byte, r));
          parsed_q.insert(parsed_q.size(), req_q[0].want);
        end else if (parse_byte(in_restart, in_byte, r)) begin
          parsed_q.insert(parsed_q.size(), r);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == 2000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n ? idle_now() : 1'b0;
  end

  function automatic void add_req(logic rst, logic [7:0] b);
    req_t q;
    q.rst = rst;
    q.data = b;
    q.chk = 1'b0;
    q.want = '0;
    req_q.insert(req_q.size(), q);
    if (!rst) req_count++;
  endfunction

  function automatic void add_row(row_kind_t k, logic rst, logic [7:0] b, logic chk,
                                  res_t want);
    row_t row;
    row.kind = k;
    row.req.rst = rst;
    row.req.data = b;
    row.req.chk = chk;
    row.req.want = want;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // Mostly well-formed frames with short payloads; some are cut short by a
  // restart, and a few are raw noise followed by a restart.
  task automatic queue_random_frame();
    logic [7:0] hdr[$];
    logic [63:0] plen;
    logic [7:0] b1;
    int pick;
    int npay;
    int total;
    int cut;
    bit chop;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 6)) add_req(1'($urandom_range(0, 1)), 8'($urandom));
      add_req(1'b1, 8'($urandom));
      return;
    end
    b1 = 8'($urandom);
    hdr.insert(hdr.size(), 8'($urandom));
    if (pick < 60) begin
      plen = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 10));
      b1[6:0] = plen[6:0];
      hdr.insert(hdr.size(), b1);
    end else if (pick < 80) begin
      plen = ($urandom_range(0, 6) == 0) ? 64'($urandom_range(0, 65535))
                                         : 64'($urandom_range(0, 30));
      b1[6:0] = LEN7_EXT16;
      hdr.insert(hdr.size(), b1);
      hdr.insert(hdr.size(), plen[15:8]);
      hdr.insert(hdr.size(), plen[7:0]);
    end else begin
      plen = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
                                         : 64'($urandom_range(0, 30));
      b1[6:0] = LEN7_EXT64;
      hdr.insert(hdr.size(), b1);
      for (int i = 7; i >= 0; i--) hdr.insert(hdr.size(), plen[8*i +: 8]);
    end
    if (b1[7]) repeat (4) hdr.insert(hdr.size(), 8'($urandom));
    // Long payloads are never sent whole; a restart abandons them.
    chop = (plen > 64'd200) || ($urandom_range(0, 99) < 8);
    npay = (plen > 64'd200) ? int'($urandom_range(0, 6)) : int'(plen);
    total = hdr.size() + npay;
    cut = chop ? int'($urandom_range(0, total)) : total;
    for (int i = 0; i < cut; i++) add_req(1'b0, (i < hdr.size()) ? hdr[i] : 8'($urandom));
    if (chop) add_req(1'b1, 8'($urandom));
  endtask

  task automatic send_requests();
    while (req_q.size() != 0 || in_valid) begin
      @(negedge clk);
      if (in_valid && !in_taken) continue;
      if (in_taken) begin
        void'(req_q.pop_front());
        in_taken = 1'b0;
      end
      if (req_q.size() == 0 || idle_now()) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_restart <= req_q[0].rst;
        in_byte <= req_q[0].data;
      end
    end
  endtask

  // A request may leave the block busy without a result, so settle keeps
  // clocking after the last expected one.
  task automatic settle();
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_unmask(logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    unmask_on = v;
  endtask

  initial begin
    clear_frame();
    unmask_on = 1'b1;

    // Zero-length frame: the header result closes it.
    add_row(ROW_REQ, 1'b0, 8'h81, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h00, 1'b1, {KIND_HEADER, 8'h81, 1'b0, 64'd0, 8'h00, 1'b1});
    // Masked frame of two bytes; unmasking is switched off between them.
    add_row(ROW_REQ, 1'b0, 8'h7F, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h82, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'hFF, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h00, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'hAA, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h55, 1'b1, {KIND_HEADER, 8'h7F, 1'b1, 64'd2, 8'h00, 1'b0});
    add_row(ROW_REQ, 1'b0, 8'h0F, 1'b1, {KIND_DATA, 8'h7F, 1'b1, 64'd2, 8'hF0, 1'b0});
    add_row(ROW_CFG, 1'b0, 8'h00, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h3C, 1'b0, '0);
    // 64-bit length with every bit set is taken as is; a restart drops the frame.
    add_row(ROW_REQ, 1'b0, 8'h88, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h7F, 1'b0, '0);
    for (int i = 0; i < 7; i++) add_row(ROW_REQ, 1'b0, 8'hFF, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'hFF, 1'b1,
            {KIND_HEADER, 8'h88, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0});
    add_row(ROW_REQ, 1'b1, 8'hA5, 1'b0, '0);
    // 16-bit extended length of one.
    add_row(ROW_REQ, 1'b0, 8'h00, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h7E, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h00, 1'b0, '0);
    add_row(ROW_REQ, 1'b0, 8'h01, 1'b1, {KIND_HEADER, 8'h00, 1'b0, 64'd1, 8'h00, 1'b0});
    add_row(ROW_REQ, 1'b0, 8'hFF, 1'b1, {KIND_DATA, 8'h00, 1'b0, 64'd1, 8'hFF, 1'b1});
    add_row(ROW_CFG, 1'b0, 8'h01, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        send_requests();
        settle();
        write_unmask(dir_tab[i].req.data[0]);
      end else begin
        req_q.insert(req_q.size(), dir_tab[i].req);
      end
    end
    send_requests();
    settle();

    req_count = 0;
    for (int p = 0; p < 3; p++) begin
      write_unmask((p == 1) ? 1'b0 : 1'b1);
      while (req_count < 300 * (p + 1)) queue_random_frame();
      send_requests();
      settle();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
